// ----- design/pps_pkg.sv -----
// Shared types and codes for the preemptive priority scheduler.
`default_nettype none
package pps_pkg;

  // Request command codes
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Request payload
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [3:0]  running_slot;
    logic        idle;
    logic        slice_start;
    logic [15:0] time_now;
    logic        proc_finished;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;
    logic        load_error;
  } rsp_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_DRAIN = 2'd2,
    S_EMIT  = 2'd3
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // take the request, restart the scan
    logic scan_step;  // read the next slot
    logic commit;     // update state and load the response register
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t req_cmd;
    logic scan_done;
  } stat_t;

endpackage
`default_nettype wire

// ----- design/preemptive_priority_scheduler_unit.sv -----
// Top level of the preemptive priority scheduler.
`default_nettype none
// Tick-driven preemptive priority scheduler over up to MAX_PROCS process
// slots. Each request is a load (append a process), a tick (run the best
// eligible slot for one time unit) or a clear (empty the table, time to zero);
// every request yields exactly one response. Requests are handled one at a
// time. A tick scans the loaded slots before it responds: the slot tables
// sit in single-read-port memories, so the candidate scan reads one slot per
// cycle, followed by a compare-drain state and a commit state. Load, clear
// and unused commands skip the scan and go straight to commit. The next
// request is taken in the cycle after the response is registered, even if
// the response has not yet been taken. Time saturates at 2^TIME_BITS - 1.
module preemptive_priority_scheduler_unit #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_ready,
  input  wire pps_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire                 rsp_ready,
  output pps_pkg::rsp_t       rsp
);
  import pps_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer
  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Tables, scan and update
  pps_dp #(
    .MAX_PROCS (MAX_PROCS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .ctrl (ctrl),
    .stat (stat),
    .rsp  (rsp)
  );

`ifndef SYNTHESIS
  // One request at a time: acceptance closes the input until the response
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while another was in flight");

  // A commit always presents a response
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |=> rsp_valid)
    else $error("commit did not raise response valid");

  // A response appears only from a commit
  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(ctrl.commit))
    else $error("response valid without a commit");
`endif

endmodule
`default_nettype wire

// ----- design/pps_ctrl.sv -----
// Sequencing state machine of the scheduler: accept, scan, drain, emit.
`default_nettype none
module pps_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  wire                  rsp_ready,
  input  wire pps_pkg::stat_t  stat,
  output pps_pkg::ctrl_t       ctrl
);
  import pps_pkg::*;

  state_t state, state_next;
  logic   out_free;

  // Response register can take a new value
  assign out_free = !rsp_valid || rsp_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (stat.req_cmd == CMD_TICK) ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    req_ready      = 1'b0;
    ctrl.capture   = 1'b0;
    ctrl.scan_step = 1'b0;
    ctrl.commit    = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready    = 1'b1;
        ctrl.capture = req_valid;
      end
      S_SCAN: begin
        ctrl.scan_step = !stat.scan_done;
      end
      S_DRAIN: begin
      end
      S_EMIT: begin
        ctrl.commit = out_free;
      end
      default: begin
      end
    endcase
  end

  // Response valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- design/pps_dp.sv -----
// Datapath of the scheduler: slot tables, candidate scan and state update.
`default_nettype none
module pps_dp #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire pps_pkg::req_t   req,
  input  wire pps_pkg::ctrl_t  ctrl,
  output pps_pkg::stat_t       stat,
  output pps_pkg::rsp_t        rsp
);
  import pps_pkg::*;

  localparam int SLOT_W = $clog2(MAX_PROCS);
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int WIDE   = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int SW4    = (SLOT_W > 4) ? SLOT_W : 4;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  // Slot tables
  logic [TIME_BITS-1:0] arr_mem [MAX_PROCS];
  logic [15:0]          bst_mem [MAX_PROCS];
  logic [15:0]          rem_mem [MAX_PROCS];
  logic [7:0]           pri_mem [MAX_PROCS];

  // Captured request and scheduler state
  req_t                 cur;
  logic [CNT_W-1:0]     loaded_count, loaded_count_next;
  logic [CNT_W-1:0]     finished_count, finished_count_next;
  logic [TIME_BITS-1:0] clock_time, clock_time_next;
  logic                 last_valid, last_valid_next;
  logic [SLOT_W-1:0]    last_run, last_run_next;

  // Scan pipeline
  logic [CNT_W-1:0]     scan_idx;
  logic                 rd_valid;
  logic [SLOT_W-1:0]    rd_slot;
  logic [TIME_BITS-1:0] rd_arr;
  logic [15:0]          rd_bst, rd_rem;
  logic [7:0]           rd_pri;

  // Best candidate so far
  logic                 found;
  logic [SLOT_W-1:0]    best_slot;
  logic [TIME_BITS-1:0] best_arr;
  logic [15:0]          best_bst, best_rem;
  logic [7:0]           best_pri;

  logic eligible, better, take;

  // Commit-time values
  logic                 ld_we, tk_we;
  logic [TIME_BITS-1:0] after;
  logic [WIDE-1:0]      arr_in_w, tnow_w, after_w, best_arr_w, best_bst_w, tat_w, wt_w;
  logic [SW4-1:0]       slot_w;
  logic                 fin;
  rsp_t                 rsp_next;

  assign stat.req_cmd   = cmd_t'(req.cmd);
  assign stat.scan_done = (scan_idx == loaded_count);

  // Request capture
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cur <= req;
    end
  end

  // Slot read, one per scan step
  always_ff @(posedge clk) begin
    if (ctrl.scan_step) begin
      rd_arr  <= arr_mem[scan_idx[SLOT_W-1:0]];
      rd_bst  <= bst_mem[scan_idx[SLOT_W-1:0]];
      rd_rem  <= rem_mem[scan_idx[SLOT_W-1:0]];
      rd_pri  <= pri_mem[scan_idx[SLOT_W-1:0]];
      rd_slot <= scan_idx[SLOT_W-1:0];
    end
  end

  // Scan counter and read-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= ctrl.scan_step;
      if (ctrl.capture) begin
        scan_idx <= '0;
      end else if (ctrl.scan_step) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
    end
  end

  // Candidate compare: priority, then remaining work, then arrival
  always_comb begin
    eligible = rd_valid && (rd_arr <= clock_time) && (rd_rem != 16'd0);
    if (rd_pri != best_pri) begin
      better = rd_pri < best_pri;
    end else if (rd_rem != best_rem) begin
      better = rd_rem < best_rem;
    end else begin
      better = rd_arr < best_arr;
    end
    take = eligible && (!found || better);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.capture) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_slot <= rd_slot;
      best_arr  <= rd_arr;
      best_bst  <= rd_bst;
      best_rem  <= rd_rem;
      best_pri  <= rd_pri;
    end
  end

  // Commit: next state and response
  always_comb begin
    after      = (clock_time == TMAX) ? clock_time : clock_time + TIME_BITS'(1);
    arr_in_w   = WIDE'(cur.arrival);
    tnow_w     = WIDE'(clock_time);
    after_w    = WIDE'(after);
    best_arr_w = WIDE'(best_arr);
    best_bst_w = WIDE'(best_bst);
    slot_w     = SW4'(best_slot);
    fin        = (best_rem == 16'd1);
    tat_w      = (after_w >= best_arr_w) ? after_w - best_arr_w : '0;
    wt_w       = (tat_w >= best_bst_w) ? tat_w - best_bst_w : '0;

    ld_we               = 1'b0;
    tk_we               = 1'b0;
    loaded_count_next   = loaded_count;
    finished_count_next = finished_count;
    clock_time_next     = clock_time;
    last_valid_next     = last_valid;
    last_run_next       = last_run;
    rsp_next            = '0;
    rsp_next.time_now   = tnow_w[15:0];

    case (cmd_t'(cur.cmd))
      CMD_LOAD: begin
        if (cur.burst == 16'd0 || loaded_count >= CNT_W'(MAX_PROCS)) begin
          rsp_next.load_error = 1'b1;
        end else begin
          ld_we             = 1'b1;
          loaded_count_next = loaded_count + CNT_W'(1);
        end
      end
      CMD_TICK: begin
        clock_time_next = after;
        if (!found) begin
          rsp_next.idle = 1'b1;
        end else begin
          tk_we                 = 1'b1;
          rsp_next.running_slot = slot_w[3:0];
          rsp_next.slice_start  = !last_valid || (last_run != best_slot);
          last_valid_next       = 1'b1;
          last_run_next         = best_slot;
          if (fin) begin
            rsp_next.proc_finished = 1'b1;
            rsp_next.turnaround    = tat_w[15:0];
            rsp_next.waiting       = wt_w[15:0];
            finished_count_next    = finished_count + CNT_W'(1);
          end
        end
      end
      CMD_CLEAR: begin
        loaded_count_next   = '0;
        finished_count_next = '0;
        clock_time_next     = '0;
        last_valid_next     = 1'b0;
        last_run_next       = '0;
        rsp_next.time_now   = '0;
      end
      CMD_NOP: begin
      end
      default: begin
      end
    endcase
    rsp_next.all_done = (finished_count_next == loaded_count_next);
  end

  // Scheduler state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count   <= '0;
      finished_count <= '0;
      clock_time     <= '0;
      last_valid     <= 1'b0;
      last_run       <= '0;
    end else if (ctrl.commit) begin
      loaded_count   <= loaded_count_next;
      finished_count <= finished_count_next;
      clock_time     <= clock_time_next;
      last_valid     <= last_valid_next;
      last_run       <= last_run_next;
    end
  end

  // Table writes: a load fills a new slot, a tick charges the winner
  always_ff @(posedge clk) begin
    if (ctrl.commit && ld_we) begin
      arr_mem[loaded_count[SLOT_W-1:0]] <= arr_in_w[TIME_BITS-1:0];
      bst_mem[loaded_count[SLOT_W-1:0]] <= cur.burst;
      rem_mem[loaded_count[SLOT_W-1:0]] <= cur.burst;
      pri_mem[loaded_count[SLOT_W-1:0]] <= cur.prio;
    end else if (ctrl.commit && tk_we) begin
      rem_mem[best_slot] <= best_rem - 16'd1;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

// ----- tb/preemptive_priority_scheduler_unit_tb.sv -----
// Self-checking testbench for the preemptive priority scheduler unit.
`timescale 1ns / 1ps
module preemptive_priority_scheduler_unit_tb;
  import pps_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [15:0] TIME_TOP = 16'hFFFF;
  localparam int PHASE_ITEMS = 250;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 64;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Request and response traffic
  req_t pending_req [$];
  rsp_t expected_rsp [$];
  bit req_taken = 1'b0;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int phase_items = 0;

  // Long receiver hold-off
  bit hold_request = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  // Scheduler shadow state
  logic [15:0] slot_arrival [SLOTS];
  logic [15:0] slot_burst [SLOTS];
  logic [15:0] slot_left [SLOTS];
  logic [7:0] slot_prio [SLOTS];
  int loaded_cnt = 0;
  int done_cnt = 0;
  logic [15:0] sched_now = '0;
  bit ran_any = 1'b0;
  int last_slot = 0;

  preemptive_priority_scheduler_unit #(
    .MAX_PROCS(SLOTS),
    .TIME_BITS(16)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #2 clk = ~clk;

  // Advance the shadow scheduler by one request, return its response
  function automatic rsp_t schedule_step(req_t r);
    rsp_t o;
    logic [15:0] tnow;
    logic [15:0] after;
    logic [15:0] tat;
    int best;
    bit found;
    bit take;
    o = '0;
    tnow = sched_now;
    o.time_now = tnow;
    case (r.cmd)
      CMD_LOAD: begin
        if (r.burst == 16'd0 || loaded_cnt >= SLOTS) begin
          o.load_error = 1'b1;
        end else begin
          slot_arrival[loaded_cnt] = r.arrival;
          slot_burst[loaded_cnt] = r.burst;
          slot_left[loaded_cnt] = r.burst;
          slot_prio[loaded_cnt] = r.prio;
          loaded_cnt++;
        end
      end
      CMD_CLEAR: begin
        loaded_cnt = 0;
        done_cnt = 0;
        sched_now = '0;
        ran_any = 1'b0;
        last_slot = 0;
        o.time_now = '0;
      end
      CMD_TICK: begin
        found = 1'b0;
        best = 0;
        // lowest prio, then least remaining, then earliest arrival, then slot
        for (int i = 0; i < loaded_cnt; i++) begin
          if (slot_arrival[i] > tnow || slot_left[i] == 16'd0) continue;
          if (!found) take = 1'b1;
          else if (slot_prio[i] != slot_prio[best]) take = slot_prio[i] < slot_prio[best];
          else if (slot_left[i] != slot_left[best]) take = slot_left[i] < slot_left[best];
          else take = slot_arrival[i] < slot_arrival[best];
          if (take) begin
            best = i;
            found = 1'b1;
          end
        end
        after = (tnow == TIME_TOP) ? TIME_TOP : tnow + 16'd1;
        sched_now = after;
        if (!found) begin
          o.idle = 1'b1;
        end else begin
          o.running_slot = best[3:0];
          o.slice_start = !ran_any || last_slot != best;
          ran_any = 1'b1;
          last_slot = best;
          slot_left[best] = slot_left[best] - 16'd1;
          if (slot_left[best] == 16'd0) begin
            o.proc_finished = 1'b1;
            tat = (after >= slot_arrival[best]) ? after - slot_arrival[best] : 16'd0;
            o.turnaround = tat;
            o.waiting = (tat >= slot_burst[best]) ? tat - slot_burst[best] : 16'd0;
            done_cnt++;
          end
        end
      end
      default: ;
    endcase
    o.all_done = (done_cnt == loaded_cnt);
    return o;
  endfunction

  // Compare one response with the oldest expectation
  task automatic check_response(rsp_t got);
    rsp_t exp;
    if (expected_rsp.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("response with nothing expected: slot=%0d idle=%0b t=%0d",
                 got.running_slot, got.idle, got.time_now);
      return;
    end
    exp = expected_rsp.pop_front();
    if (got.running_slot !== exp.running_slot || got.idle !== exp.idle ||
        got.slice_start !== exp.slice_start || got.time_now !== exp.time_now ||
        got.proc_finished !== exp.proc_finished || got.turnaround !== exp.turnaround ||
        got.waiting !== exp.waiting || got.all_done !== exp.all_done ||
        got.load_error !== exp.load_error) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display(
          "mismatch exp: slot=%0d idle=%0b slc=%0b t=%0d fin=%0b tat=%0d wt=%0d dn=%0b er=%0b",
          exp.running_slot, exp.idle, exp.slice_start, exp.time_now,
          exp.proc_finished, exp.turnaround, exp.waiting, exp.all_done,
          exp.load_error);
        $display(
          "         got: slot=%0d idle=%0b slc=%0b t=%0d fin=%0b tat=%0d wt=%0d dn=%0b er=%0b",
          got.running_slot, got.idle, got.slice_start, got.time_now,
          got.proc_finished, got.turnaround, got.waiting, got.all_done,
          got.load_error);
      end
    end
  endtask

  // Monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    cycle_count++;
    req_taken = req_valid && req_ready;
    if (!rst) begin
      if (rsp_valid && rsp_ready) check_response(rsp);
      if (req_taken) expected_rsp.push_back(schedule_step(req));
    end
  end

  // Request driver
  always @(negedge clk) begin
    if (req_valid && !req_taken) begin
      // hold until accepted
    end else if (pending_req.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
      req <= pending_req.pop_front();
      req_valid <= 1'b1;
    end else begin
      req_valid <= 1'b0;
    end
  end

  // Response ready driver
  always @(negedge clk) begin
    rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
  end

  // Hold-off counter
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Timeout
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("preemptive_priority_scheduler_unit_tb failed");
    $finish;
  end

  task automatic next_cycle();
    @(posedge clk);
    #1;
  endtask

  task automatic push_req(cmd_t c, logic [15:0] arr, logic [15:0] bst, logic [7:0] pr);
    req_t r;
    r.cmd = c;
    r.arrival = arr;
    r.burst = bst;
    r.prio = pr;
    pending_req.push_back(r);
    if (c != CMD_NOP) phase_items++;
  endtask

  // Payload-only noise for commands that ignore the process fields
  task automatic push_cmd(cmd_t c);
    push_req(c, 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Random load, mostly small values with ties; returns burst if <= 4, else 0
  task automatic push_rand_load(output int work);
    logic [15:0] arr;
    logic [15:0] bst;
    logic [7:0] pr;
    int pick;
    arr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    pick = $urandom_range(0, 99);
    if (pick < 5) bst = '0;
    else if (pick < 8) bst = 16'($urandom);
    else bst = 16'($urandom_range(1, 4));
    pr = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    push_req(CMD_LOAD, arr, bst, pr);
    work = (bst <= 16'd4) ? int'(bst) : 0;
  endtask

  // One scheduling run: usually a clear, loads, then ticks, with some noise
  task automatic push_sequence();
    int nproc;
    int work;
    int w;
    int nticks;
    int pick;
    if ($urandom_range(0, 9) != 0) push_cmd(CMD_CLEAR);
    nproc = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
    work = 0;
    for (int i = 0; i < nproc; i++) begin
      push_rand_load(w);
      work += w;
    end
    nticks = work + $urandom_range(0, 12);
    for (int t = 0; t < nticks; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        push_cmd(CMD_NOP);
      end else if (pick < 5) begin
        push_cmd(CMD_CLEAR);
        break;
      end else if (pick < 9) begin
        push_rand_load(w);
      end
      push_cmd(CMD_TICK);
    end
  endtask

  task automatic wait_drained();
    while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0) next_cycle();
  endtask

  // Stimulus
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    next_cycle();

    // Directed: empty tick, unused code, zero burst, all tie-breaks,
    // preemption, never-arriving process, idle gap, clear
    push_cmd(CMD_TICK);
    push_cmd(CMD_NOP);
    push_req(CMD_LOAD, 16'd0, 16'd0, 8'd1);
    push_req(CMD_LOAD, 16'd0, 16'd3, 8'd5);
    push_req(CMD_LOAD, 16'd0, 16'd2, 8'd5);
    push_req(CMD_LOAD, 16'd1, 16'd2, 8'd5);
    push_req(CMD_LOAD, 16'd0, 16'd2, 8'd5);
    push_req(CMD_LOAD, 16'd2, 16'd1, 8'd0);
    push_req(CMD_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF);
    push_req(CMD_LOAD, 16'd12, 16'd1, 8'd7);
    repeat (13) push_cmd(CMD_TICK);
    push_cmd(CMD_CLEAR);
    push_cmd(CMD_TICK);
    wait_drained();

    // Random phases with different idling; long hold-off in the first
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_request = 1'b1; end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) push_sequence();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    #1;
    if (mismatch_count == 0 && expected_rsp.size() == 0)
      $display("preemptive_priority_scheduler_unit_tb passed");
    else
      $display("preemptive_priority_scheduler_unit_tb failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pps_pkg.sv
design/pps_ctrl.sv
design/pps_dp.sv
design/preemptive_priority_scheduler_unit.sv
tb/preemptive_priority_scheduler_unit_tb.sv
